// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, idle while rst_n is low.
`define CHK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, idle while rst_n is low.
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/chng_pkg.sv =====
// Package with the widths, control types and character folding of the n-gram histogram.
`timescale 1ns / 1ps

package chng_pkg;

  // Character and counter sizing.
  localparam int CHAR_BITS  = 7;
  localparam int COUNT_BITS = 32;
  localparam int OUT_BITS   = 32;
  localparam int KEY_BITS   = 7;
  localparam int PAIR_AW    = 2 * CHAR_BITS;
  localparam int TRI_AW     = 3 * CHAR_BITS;

  localparam logic [KEY_BITS-1:0] SPACE_CHAR = 7'd32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic update;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

  // Fold one raw byte to its counted character.
  function automatic logic [KEY_BITS-1:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    begin
      case (b)
        8'h7B:   r = 8'h5B;  // brace to bracket
        8'h7D:   r = 8'h5D;
        8'h7C:   r = 8'h5C;  // bar to backslash
        8'h3F:   r = 8'h2F;  // question mark to slash
        8'h3E:   r = 8'h2E;
        8'h3C:   r = 8'h2C;
        8'h3A:   r = 8'h3B;
        8'h5F:   r = 8'h2D;
        8'h2B:   r = 8'h3D;
        default: begin
          if (b <= 8'd32) begin
            r = 8'd32;
          end else if (b <= 8'd64) begin
            r = b;
          end else if (b <= 8'd90) begin
            r = b + 8'd32;
          end else if (b <= 8'd126) begin
            r = b;
          end else begin
            r = 8'd32;
          end
        end
      endcase
      return r[KEY_BITS-1:0];
    end
  endfunction

  // Clamp a counter to the width of the result ports.
  function automatic logic [OUT_BITS-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+OUT_BITS-1:0] w;
    begin
      w = {{OUT_BITS{1'b0}}, v};
      if (w[COUNT_BITS+OUT_BITS-1:OUT_BITS] != '0) begin
        return '1;
      end
      return w[OUT_BITS-1:0];
    end
  endfunction

  // Saturating increment.
  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    begin
      if (v == '1) begin
        return v;
      end
      return v + 1'b1;
    end
  endfunction

endpackage

// ===== hw/rtl/chng_ctrl.sv =====
// Controller state machine: clearing pass, idle and table update.
`timescale 1ns / 1ps

module chng_ctrl import chng_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    cmd.clear   = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== hw/rtl/chng_dp.sv =====
// Datapath: count memories, character history, total and result registers.
`timescale 1ns / 1ps

module chng_dp import chng_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  in_func,
  input  logic [7:0]            in_byte,
  input  logic [KEY_BITS-1:0]   in_first_key,
  input  logic [KEY_BITS-1:0]   in_second_key,
  input  logic [KEY_BITS-1:0]   in_third_key,
  output logic                  out_valid,
  output logic [KEY_BITS-1:0]   out_folded_char,
  output logic [OUT_BITS-1:0]   out_single_count,
  output logic [OUT_BITS-1:0]   out_pair_count,
  output logic [OUT_BITS-1:0]   out_triple_count,
  output logic [OUT_BITS-1:0]   out_char_total
);

  // Count memories.
  logic [COUNT_BITS-1:0] sgl_mem [2**CHAR_BITS];
  logic [COUNT_BITS-1:0] pair_mem [2**PAIR_AW];
  logic [COUNT_BITS-1:0] tri_mem [2**TRI_AW];

  logic [COUNT_BITS-1:0] sgl_rdata_r, pair_rdata_r, tri_rdata_r;

  // Clearing pass address.
  logic [TRI_AW-1:0] clr_cnt_r;

  // Request captured at acceptance.
  logic                func_r;
  logic [KEY_BITS-1:0] char_r;
  logic [CHAR_BITS-1:0] sgl_addr_r;
  logic [PAIR_AW-1:0]  pair_addr_r;
  logic [TRI_AW-1:0]   tri_addr_r;

  // Character history and total.
  logic [KEY_BITS-1:0]   prev_char_r, prev_prev_char_r;
  logic [1:0]            fill_r;
  logic [COUNT_BITS-1:0] total_r, total_nxt;

  logic [KEY_BITS-1:0]  fold_c;
  logic [CHAR_BITS-1:0] new_sgl_addr;
  logic [PAIR_AW-1:0]   new_pair_addr;
  logic [TRI_AW-1:0]    new_tri_addr;
  logic [CHAR_BITS-1:0] sgl_addr;
  logic [PAIR_AW-1:0]   pair_addr;
  logic [TRI_AW-1:0]    tri_addr;
  logic                 sgl_we, pair_we, tri_we, do_count;
  logic [COUNT_BITS-1:0] sgl_wdata, pair_wdata, tri_wdata;

  assign fold_c = fold_byte(in_byte);

  // Addresses of a new request: the keys on a read, the history on a count.
  always_comb begin
    if (in_func) begin
      new_sgl_addr  = in_first_key[CHAR_BITS-1:0];
      new_pair_addr = {in_first_key[CHAR_BITS-1:0], in_second_key[CHAR_BITS-1:0]};
      new_tri_addr  = {in_first_key[CHAR_BITS-1:0], in_second_key[CHAR_BITS-1:0],
                       in_third_key[CHAR_BITS-1:0]};
    end else begin
      new_sgl_addr  = fold_c[CHAR_BITS-1:0];
      new_pair_addr = {prev_char_r[CHAR_BITS-1:0], fold_c[CHAR_BITS-1:0]};
      new_tri_addr  = {prev_prev_char_r[CHAR_BITS-1:0], prev_char_r[CHAR_BITS-1:0],
                       fold_c[CHAR_BITS-1:0]};
    end
  end

  // Memory port control: sweep, write-back of the held address, or lookup.
  assign do_count = cmd.update && !func_r;

  always_comb begin
    if (cmd.clear) begin
      sgl_addr  = clr_cnt_r[CHAR_BITS-1:0];
      pair_addr = clr_cnt_r[PAIR_AW-1:0];
      tri_addr  = clr_cnt_r;
    end else if (cmd.update) begin
      sgl_addr  = sgl_addr_r;
      pair_addr = pair_addr_r;
      tri_addr  = tri_addr_r;
    end else begin
      sgl_addr  = new_sgl_addr;
      pair_addr = new_pair_addr;
      tri_addr  = new_tri_addr;
    end
    sgl_we     = cmd.clear || do_count;
    pair_we    = cmd.clear || (do_count && (fill_r != 2'd0));
    tri_we     = cmd.clear || (do_count && (fill_r == 2'd2));
    sgl_wdata  = cmd.clear ? '0 : bump(sgl_rdata_r);
    pair_wdata = cmd.clear ? '0 : bump(pair_rdata_r);
    tri_wdata  = cmd.clear ? '0 : bump(tri_rdata_r);
  end

  // Single-port memories with registered read data.
  always_ff @(posedge clk) begin
    if (sgl_we) begin
      sgl_mem[sgl_addr] <= sgl_wdata;
    end
    sgl_rdata_r <= sgl_mem[sgl_addr];
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_addr] <= pair_wdata;
    end
    pair_rdata_r <= pair_mem[pair_addr];
  end

  always_ff @(posedge clk) begin
    if (tri_we) begin
      tri_mem[tri_addr] <= tri_wdata;
    end
    tri_rdata_r <= tri_mem[tri_addr];
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign stat.clear_last = &clr_cnt_r;

  // Capture the request at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r      <= in_func;
      char_r      <= fold_c;
      sgl_addr_r  <= new_sgl_addr;
      pair_addr_r <= new_pair_addr;
      tri_addr_r  <= new_tri_addr;
    end
  end

  assign total_nxt = do_count ? bump(total_r) : total_r;

  // History and total update on a count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_char_r      <= '0;
      prev_prev_char_r <= '0;
      fill_r           <= '0;
      total_r          <= '0;
    end else if (do_count) begin
      prev_prev_char_r <= prev_char_r;
      prev_char_r      <= char_r;
      if (fill_r != 2'd2) begin
        fill_r <= fill_r + 2'd1;
      end
      total_r <= total_nxt;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.update;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_char_total <= clamp_out(total_nxt);
      if (func_r) begin
        out_folded_char  <= '0;
        out_single_count <= clamp_out(sgl_rdata_r);
        out_pair_count   <= clamp_out(pair_rdata_r);
        out_triple_count <= clamp_out(tri_rdata_r);
      end else begin
        out_folded_char  <= char_r;
        out_single_count <= '0;
        out_pair_count   <= '0;
        out_triple_count <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/char_ngram_histogram.sv =====
// Top level of the character n-gram histogram: controller, datapath and checks.
`timescale 1ns / 1ps
// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// in_func low counts in_byte: the byte is folded and the single, pair and
// triple counts for it and the up to two characters before it are incremented.
// in_func high reads the counts of the triple in_first_key, in_second_key,
// in_third_key (and of its first one and first two keys).
// Each request gives exactly one result, shown for one cycle with out_valid
// high. The receiver cannot stall.
// busy is high for one cycle after each acceptance, so a new request is taken
// only once the last one has read and written back the single-port count
// memories.
// After reset the block sweeps all three count memories to zero, one
// triple-table entry per cycle, with busy high. The history and the character
// total are cleared by reset at once.
// All count memories and the character total saturate at their all-ones value.
module char_ngram_histogram import chng_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [7:0]          in_byte,
  input  logic [KEY_BITS-1:0] in_first_key,
  input  logic [KEY_BITS-1:0] in_second_key,
  input  logic [KEY_BITS-1:0] in_third_key,
  output logic                out_valid,
  output logic [KEY_BITS-1:0] out_folded_char,
  output logic [OUT_BITS-1:0] out_single_count,
  output logic [OUT_BITS-1:0] out_pair_count,
  output logic [OUT_BITS-1:0] out_triple_count,
  output logic [OUT_BITS-1:0] out_char_total
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  chng_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  chng_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_byte          (in_byte),
    .in_first_key     (in_first_key),
    .in_second_key    (in_second_key),
    .in_third_key     (in_third_key),
    .out_valid        (out_valid),
    .out_folded_char  (out_folded_char),
    .out_single_count (out_single_count),
    .out_pair_count   (out_pair_count),
    .out_triple_count (out_triple_count),
    .out_char_total   (out_char_total)
  );

  `include "assert_macros.svh"

  // An accepted request holds off the next one for its write-back cycle.
  `CHK_NEXT(a_busy_after_accept, start && !busy, busy)
  // Each accepted request raises out_valid after its read and its write-back.
  `CHK_SAME(a_result_latency, start && !busy, ##2 out_valid)
  // A result shows up only once the block is free again.
  `CHK_SAME(a_idle_on_result, out_valid, !busy)
  // A count result carries no table counts; a read result carries no character.
  `CHK_SAME(a_result_kind, out_valid,
            (out_folded_char == '0) || ((out_single_count == '0) &&
            (out_pair_count == '0) && (out_triple_count == '0)))

endmodule
